// File: hdl/hsc_pkg.sv
`timescale 1ns / 1ps

package hsc_pkg;

   // Command codes carried by an input item.
   typedef logic [2:0] cmd_type;

   localparam cmd_type CMD_LOOKUP        = 3'd0;
   localparam cmd_type CMD_INSERT        = 3'd1;
   localparam cmd_type CMD_REMOVE        = 3'd2;
   localparam cmd_type CMD_REMOVE_DEVICE = 3'd3;
   localparam cmd_type CMD_FLUSH         = 3'd4;

   // Multiplier of the set hash and the source id that marks a way as unused.
   localparam logic [31:0] HASH_MULT = 32'h9E37_0001;
   localparam logic [31:0] UNUSED_ID = 32'hFFFF_FFFF;

   // One input item as it is held inside the block.
   typedef struct packed {
      cmd_type            cmd;
      logic [31:0]        file_number;
      logic [31:0]        device_id;
      logic signed [31:0] entry_src_id;
   } item_type;

   // Key and payload of one way, as stored in the tag memory.
   typedef struct packed {
      logic [31:0] file_number;
      logic [31:0] device_id;
      logic [31:0] src_id;
   } way_tag_type;

   localparam int TAG_W = $bits(way_tag_type);

endpackage

// File: hdl/hsc_if.sv
`timescale 1ns / 1ps

// Request channel: one command item.
interface hsc_req_if;
   logic               valid;
   logic               ready;
   hsc_pkg::cmd_type   cmd;
   logic [31:0]        file_number;
   logic [31:0]        device_id;
   logic signed [31:0] entry_src_id;

   modport source (output valid, output cmd, output file_number, output device_id,
                   output entry_src_id, input ready);
   modport sink (input valid, input cmd, input file_number, input device_id,
                 input entry_src_id, output ready);
endinterface

// Response channel: one result item per command.
interface hsc_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] found_src_id;

   modport source (output valid, output hit, output found_src_id, input ready);
   modport sink (input valid, input hit, input found_src_id, output ready);
endinterface

// File: hdl/hsc_ram.sv
`timescale 1ns / 1ps

module hsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port; read data holds without a read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/hsc_way_logic.sv
`timescale 1ns / 1ps

module hsc_way_logic #(
   parameter int WAYS  = 8,
   parameter int PTR_W = 3
) (
   input  hsc_pkg::item_type             item,
   input  logic [WAYS*hsc_pkg::TAG_W-1:0] tag_row,
   input  logic [WAYS-1:0]               valid_row,
   input  logic [PTR_W-1:0]              ptr,
   output logic                          hit,
   output logic signed [31:0]            found_src_id,
   output logic [WAYS*hsc_pkg::TAG_W-1:0] tag_new,
   output logic [WAYS-1:0]               valid_new,
   output logic [PTR_W-1:0]              ptr_new
);

   import hsc_pkg::*;

   logic [WAYS-1:0]  key_match;
   logic [WAYS-1:0]  dev_match;
   logic             free_found;
   logic [PTR_W-1:0] free_way;
   logic [PTR_W-1:0] target;
   logic [PTR_W-1:0] ptr_next;
   way_tag_type      tag_w;
   way_tag_type      tag_ins;

   // Per-way key and device compares.
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         tag_w        = tag_row[w*TAG_W +: TAG_W];
         dev_match[w] = (tag_w.device_id == item.device_id);
         key_match[w] = valid_row[w] && dev_match[w] &&
                        (tag_w.file_number == item.file_number);
      end
   end

   // Lookup: the lowest matching way wins.
   always_comb begin
      hit          = 1'b0;
      found_src_id = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (key_match[w] && item.cmd == CMD_LOOKUP) begin
            hit          = 1'b1;
            found_src_id = $signed(tag_row[w*TAG_W +: 32]);
         end
      end
   end

   // Insert target: the lowest free way, else the way under the victim pointer.
   always_comb begin
      free_found = 1'b0;
      free_way   = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!valid_row[w]) begin
            free_found = 1'b1;
            free_way   = PTR_W'(w);
         end
      end
      target   = free_found ? free_way : ptr;
      ptr_next = (ptr == PTR_W'(WAYS - 1)) ? '0 : ptr + 1'b1;
   end

   // New row contents for the command held in the item.
   always_comb begin
      tag_new   = tag_row;
      valid_new = valid_row;
      ptr_new   = ptr;
      tag_ins.file_number = item.file_number;
      tag_ins.device_id   = item.device_id;
      tag_ins.src_id      = $unsigned(item.entry_src_id);
      case (item.cmd)
         CMD_INSERT: begin
            for (int w = 0; w < WAYS; w++) begin
               if (PTR_W'(w) == target) begin
                  tag_new[w*TAG_W +: TAG_W] = tag_ins;
                  valid_new[w] = ($unsigned(item.entry_src_id) != UNUSED_ID);
               end
            end
            if (!free_found || free_way == ptr) begin
               ptr_new = ptr_next;
            end
         end
         CMD_REMOVE: begin
            valid_new = valid_row & ~key_match;
         end
         CMD_REMOVE_DEVICE: begin
            valid_new = valid_row & ~dev_match;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: hdl/hashed_8way_result_cache.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake          | Payload
// req     | in  | valid/ready        | cmd, file_number, device_id, entry_src_id
// rsp     | out | valid/ready        | hit, found_src_id
//
// Lookup, insert, remove and unknown commands go from accept to result through
// hash multiply, set-index reduction, set read, then read-modify-write of the set.
// Remove device sweeps every set with a read and a write, then gives its result.
// Flush and the pass after reset clear the valid/pointer memory one set a cycle;
// only flush then gives a result, and no item is accepted meanwhile.
// One item is worked on at a time; a result waits in the output register while the
// next item is accepted, and the set write stalls until that register is free.

module hashed_8way_result_cache #(
   parameter int SETS     = 512,
   parameter int WAYS     = 8,
   parameter int SET_BITS = 9
) (
   input  logic      clock,
   input  logic      reset,
   hsc_req_if.sink   req,
   hsc_rsp_if.source rsp
);

   import hsc_pkg::*;

   localparam int IDX_W  = $clog2(SETS);
   localparam int PTR_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W  = WAYS * TAG_W;
   localparam int ST_W   = WAYS + PTR_W;
   localparam int HQ_W   = SET_BITS + 32;
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SETS));

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_HASH     = 3'd2;
   localparam logic [2:0] ST_ADDR     = 3'd3;
   localparam logic [2:0] ST_EXEC     = 3'd4;
   localparam logic [2:0] ST_SWEEP_RD = 3'd5;
   localparam logic [2:0] ST_SWEEP_WR = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [IDX_W-1:0]    set_ff, set_in;
   logic                clr_rsp_ff, clr_rsp_in;
   item_type            item_ff;
   logic [31:0]         prod_ff;
   logic [SET_BITS-1:0] h_ff;
   logic [SET_BITS-1:0] q_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic signed [31:0]  rsp_found_ff;

   logic                accept;
   logic                slot_free;
   logic                last_set;
   logic                rsp_load;
   logic                exec_go;
   logic                st_upd;
   logic [HQ_W-1:0]     hq;
   logic [32:0]         qs;
   logic [32:0]         rem_a;
   logic [32:0]         rem_b;
   logic [IDX_W-1:0]    idx;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                tag_we;
   logic                st_we;
   logic [ST_W-1:0]     st_wdata;
   logic [ROW_W-1:0]    tag_row;
   logic [ST_W-1:0]     st_row;

   logic                wl_hit;
   logic signed [31:0]  wl_found;
   logic [ROW_W-1:0]    tag_new;
   logic [WAYS-1:0]     valid_new;
   logic [PTR_W-1:0]    ptr_new;

   assign accept    = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign last_set  = (set_ff == IDX_W'(SETS - 1));
   assign exec_go   = (state_ff == ST_EXEC) && slot_free;
   assign req.ready = (state_ff == ST_IDLE);

   // Set index: a reciprocal multiply estimates the quotient, one correction fixes it.
   assign hq    = HQ_W'(prod_ff[31 -: SET_BITS]) * HQ_W'(RECIP);
   assign qs    = 33'(q_ff) * 33'(SETS);
   assign rem_a = 33'(h_ff) - qs;
   assign rem_b = (rem_a >= 33'(SETS)) ? rem_a - 33'(SETS) : rem_a;
   assign idx   = rem_b[IDX_W-1:0];

   // Commands that write the valid/pointer row back.
   always_comb begin
      unique case (item_ff.cmd) inside
         CMD_INSERT, CMD_REMOVE: st_upd = 1'b1;
         default:                st_upd = 1'b0;
      endcase
   end

   // Memory port control.
   assign rd_en    = (state_ff == ST_ADDR) || (state_ff == ST_SWEEP_RD);
   assign rd_addr  = (state_ff == ST_ADDR) ? idx : set_ff;
   assign tag_we   = exec_go && (item_ff.cmd == CMD_INSERT);
   assign st_we    = (state_ff == ST_CLEAR) || (state_ff == ST_SWEEP_WR) ||
                     (exec_go && st_upd);
   assign st_wdata = (state_ff == ST_CLEAR) ? '0 : {ptr_new, valid_new};
   assign rsp_load = exec_go || ((state_ff == ST_DONE) && slot_free);

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      set_in     = set_ff;
      clr_rsp_in = clr_rsp_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (last_set) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end else begin
               set_in = set_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               set_in = '0;
               if (req.cmd == CMD_FLUSH) begin
                  state_in   = ST_CLEAR;
                  clr_rsp_in = 1'b1;
               end else if (req.cmd == CMD_REMOVE_DEVICE) begin
                  state_in = ST_SWEEP_RD;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: state_in = ST_ADDR;
         ST_ADDR: begin
            state_in = ST_EXEC;
            set_in   = idx;
         end
         ST_EXEC: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP_RD: state_in = ST_SWEEP_WR;
         ST_SWEEP_WR: begin
            if (last_set) begin
               state_in = ST_DONE;
            end else begin
               set_in   = set_ff + 1'b1;
               state_in = ST_SWEEP_RD;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in   = ST_IDLE;
               clr_rsp_in = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         set_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         set_ff       <= set_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item, hash and result payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.cmd          <= req.cmd;
         item_ff.file_number  <= req.file_number;
         item_ff.device_id    <= req.device_id;
         item_ff.entry_src_id <= req.entry_src_id;
         prod_ff              <= req.file_number * HASH_MULT;
      end
      if (state_ff == ST_HASH) begin
         h_ff <= prod_ff[31 -: SET_BITS];
         q_ff <= hq[HQ_W-1:32];
      end
      if (rsp_load) begin
         rsp_hit_ff   <= exec_go ? wl_hit : 1'b0;
         rsp_found_ff <= exec_go ? wl_found : '0;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.hit          = rsp_hit_ff;
   assign rsp.found_src_id = rsp_found_ff;

   // Tag memory: key and source id of every way of a set in one row.
   hsc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (set_ff),
      .wr_data (tag_new),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (tag_row)
   );

   // State memory: victim pointer and valid bits of a set in one row.
   hsc_ram #(
      .WIDTH (ST_W),
      .DEPTH (SETS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (set_ff),
      .wr_data (st_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (st_row)
   );

   hsc_way_logic #(
      .WAYS  (WAYS),
      .PTR_W (PTR_W)
   ) u_way_logic (
      .item         (item_ff),
      .tag_row      (tag_row),
      .valid_row    (st_row[WAYS-1:0]),
      .ptr          (st_row[ST_W-1 -: PTR_W]),
      .hit          (wl_hit),
      .found_src_id (wl_found),
      .tag_new      (tag_new),
      .valid_new    (valid_new),
      .ptr_new      (ptr_new)
   );

   // A miss or a non-lookup result never carries a source id.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_found_ff == '0)
      else $error("result without hit carries a nonzero source id");

   // An accepted item always leaves the idle state.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted item did not start work");

   // Memories are never written while idle.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !st_we && !tag_we)
      else $error("memory write while idle");

   // The device sweep visits sets in order, one after another.
   a_sweep_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP_WR && !last_set |=> set_ff == $past(set_ff) + 1'b1)
      else $error("device sweep skipped a set");

   // Leaving reset starts the clearing pass.
   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> state_ff == ST_CLEAR)
      else $error("clearing pass not running after reset");

endmodule

// File: verif/hashed_8way_result_cache_tb.sv
`timescale 1ns / 1ps

module hashed_8way_result_cache_tb;
   import hsc_pkg::*;

   localparam int SETS     = 512;
   localparam int WAYS     = 8;
   localparam int SET_BITS = 9;

   // Codes above flush have no meaning to the block.
   localparam cmd_type CMD_RESERVED_FIRST = 3'd5;
   localparam cmd_type CMD_RESERVED_LAST  = 3'd7;

   // A device sweep is the slowest command; allow it several times over.
   localparam int STALL_LIMIT = 8000;
   localparam int TAIL_CYCLES = 40;
   localparam int HOT_SETS    = 4;
   localparam int HOT_KEYS    = 12;
   localparam int DEVICES     = 4;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] found_src_id;
   } cache_result_type;

   logic clock = 1'b0;
   logic reset;

   hsc_req_if req_bus ();
   hsc_rsp_if rsp_bus ();

   hashed_8way_result_cache #(
      .SETS(SETS),
      .WAYS(WAYS),
      .SET_BITS(SET_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus)
   );

   always #5 clock = ~clock;

   // Shadow copy of the cache contents and the per-set victim pointers.
   logic [31:0] shadow_file [SETS][WAYS];
   logic [31:0] shadow_dev  [SETS][WAYS];
   logic [31:0] shadow_src  [SETS][WAYS];
   bit          shadow_valid[SETS][WAYS];
   logic [2:0]  shadow_victim[SETS];

   cache_result_type pending_results[$];

   // Keys that collide into a few sets, so that sets fill up and evict.
   logic [31:0] hot_file[HOT_SETS][HOT_KEYS];
   logic [31:0] device_pool[DEVICES];

   bit req_idle_on;
   bit rsp_idle_on;
   int mismatch_count;
   int unexpected_count;
   int stall_cycles;
   int items_sent;
   int results_seen;
   int hits_seen;
   int cmd_count[8];

   // Set index: top bits of the 32-bit hash product.
   function automatic int set_index(input logic [31:0] file_number);
      logic [31:0] prod;
      prod = file_number * HASH_MULT;
      return int'(prod >> (32 - SET_BITS)) % SETS;
   endfunction

   function automatic logic [2:0] next_victim(input logic [2:0] way);
      return (int'(way) + 1 >= WAYS) ? 3'd0 : way + 3'd1;
   endfunction

   // Updates the shadow cache for one accepted item and returns its result.
   function automatic cache_result_type cache_predict(input item_type it);
      cache_result_type res;
      int s;
      int w;
      logic [2:0] ptr;
      res = '0;
      s = set_index(it.file_number);
      case (it.cmd)
         CMD_LOOKUP: begin
            for (w = 0; w < WAYS; w++) begin
               if (shadow_valid[s][w] && shadow_file[s][w] == it.file_number &&
                   shadow_dev[s][w] == it.device_id) begin
                  res.hit = 1'b1;
                  res.found_src_id = shadow_src[s][w];
                  break;
               end
            end
         end
         CMD_INSERT: begin
            ptr = shadow_victim[s];
            for (w = 0; w < WAYS; w++) begin
               if (!shadow_valid[s][w]) break;
            end
            if (w == WAYS) begin
               w = ptr;
               shadow_victim[s] = next_victim(ptr);
            end else if (w == int'(ptr)) begin
               shadow_victim[s] = next_victim(ptr);
            end
            shadow_file[s][w]  = it.file_number;
            shadow_dev[s][w]   = it.device_id;
            shadow_src[s][w]   = it.entry_src_id;
            shadow_valid[s][w] = (it.entry_src_id != UNUSED_ID);
         end
         CMD_REMOVE: begin
            for (w = 0; w < WAYS; w++) begin
               if (shadow_valid[s][w] && shadow_file[s][w] == it.file_number &&
                   shadow_dev[s][w] == it.device_id)
                  shadow_valid[s][w] = 1'b0;
            end
         end
         CMD_REMOVE_DEVICE: begin
            foreach (shadow_dev[t, v]) begin
               if (shadow_dev[t][v] == it.device_id) shadow_valid[t][v] = 1'b0;
            end
         end
         CMD_FLUSH: begin
            foreach (shadow_valid[t, v]) shadow_valid[t][v] = 1'b0;
            foreach (shadow_victim[t]) shadow_victim[t] = '0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Drives one item, waits for it to be taken and records its expected result.
   task automatic send_item(input item_type it);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= it.cmd;
      req_bus.file_number  <= it.file_number;
      req_bus.device_id    <= it.device_id;
      req_bus.entry_src_id <= it.entry_src_id;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(cache_predict(it));
      items_sent++;
      cmd_count[it.cmd]++;
      @(negedge clock);
   endtask

   task automatic send_fields(input cmd_type cmd, input logic [31:0] file_number,
                              input logic [31:0] device_id, input logic [31:0] src_id);
      item_type it;
      it.cmd          = cmd;
      it.file_number  = file_number;
      it.device_id    = device_id;
      it.entry_src_id = src_id;
      send_item(it);
   endtask

   // Holds the request channel idle until every outstanding result is back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] random_src_id();
      return ($urandom_range(0, 9) == 0) ? UNUSED_ID : 32'($urandom);
   endfunction

   // Mostly well-formed traffic on colliding keys, with some noise mixed in.
   function automatic item_type random_hot_item();
      item_type it;
      int pick;
      int hs;
      hs = $urandom_range(0, HOT_SETS - 1);
      it.file_number  = hot_file[hs][$urandom_range(0, HOT_KEYS - 1)];
      it.device_id    = device_pool[$urandom_range(0, DEVICES - 1)];
      it.entry_src_id = random_src_id();
      pick = $urandom_range(0, 99);
      if (pick < 38)      it.cmd = CMD_LOOKUP;
      else if (pick < 76) it.cmd = CMD_INSERT;
      else if (pick < 90) it.cmd = CMD_REMOVE;
      else if (pick < 92) it.cmd = CMD_REMOVE_DEVICE;
      else if (pick < 93) it.cmd = CMD_FLUSH;
      else if (pick < 96) it.cmd = cmd_type'($urandom_range(CMD_RESERVED_FIRST,
                                                            CMD_RESERVED_LAST));
      else begin
         it.cmd         = ($urandom_range(0, 1) == 0) ? CMD_LOOKUP : CMD_INSERT;
         it.file_number = $urandom;
         it.device_id   = $urandom;
      end
      return it;
   endfunction

   // Directed cases: field extremes, every command and the special cases.
   task automatic test_directed();
      int hs;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hs = 0;
      // Miss on an empty cache.
      send_fields(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);
      // Extremes of key and source id.
      send_fields(CMD_INSERT, 32'h0, 32'h0, 32'h7FFF_FFFF);
      send_fields(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);
      send_fields(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
      send_fields(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      // Right file number on the wrong device misses.
      send_fields(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
      // An unused source id leaves the way invalid.
      send_fields(CMD_INSERT, 32'h1234_5678, 32'h1, UNUSED_ID);
      send_fields(CMD_LOOKUP, 32'h1234_5678, 32'h1, 32'h0);
      // Fill one set past its ways so that the victim pointer evicts.
      for (int k = 0; k < WAYS + 1; k++)
         send_fields(CMD_INSERT, hot_file[hs][k], device_pool[1], 32'(k + 100));
      send_fields(CMD_LOOKUP, hot_file[hs][0], device_pool[1], 32'h0);
      send_fields(CMD_LOOKUP, hot_file[hs][WAYS], device_pool[1], 32'h0);
      // Remove a key, then look it up again.
      send_fields(CMD_REMOVE, hot_file[hs][3], device_pool[1], 32'h0);
      send_fields(CMD_LOOKUP, hot_file[hs][3], device_pool[1], 32'h0);
      // Reserved command codes change nothing.
      for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
         send_fields(cmd_type'(c), hot_file[hs][4], device_pool[1], 32'hFFFF_FFFF);
      // Sweep out one device, then flush everything.
      send_fields(CMD_REMOVE_DEVICE, 32'h0, device_pool[1], 32'h0);
      send_fields(CMD_LOOKUP, hot_file[hs][4], device_pool[1], 32'h0);
      send_fields(CMD_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);
   endtask

   task automatic test_random_idle(input int count);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (count) send_item(random_hot_item());
   endtask

   task automatic test_random_back_to_back(input int count);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (count) send_item(random_hot_item());
   endtask

   // Bursts separated by full drains of the result channel.
   task automatic test_drain_pauses(input int bursts);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      repeat (bursts) begin
         repeat ($urandom_range(3, 12)) send_item(random_hot_item());
         wait_drained();
      end
   endtask

   // Unconstrained fields; expensive commands mostly turned into lookups.
   task automatic test_noise(input int count);
      item_type it;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b0;
      repeat (count) begin
         it.cmd          = cmd_type'($urandom_range(0, 7));
         it.file_number  = $urandom;
         it.device_id    = $urandom;
         it.entry_src_id = $urandom;
         if ((it.cmd == CMD_REMOVE_DEVICE || it.cmd == CMD_FLUSH) &&
             $urandom_range(0, 9) != 0)
            it.cmd = CMD_LOOKUP;
         send_item(it);
      end
   endtask

   // Result channel: random stalls per item, with stretches of none.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      cache_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (rsp_bus.hit === 1'b1) hits_seen++;
         if (pending_results.size() == 0) begin
            unexpected_count++;
            if (unexpected_count + mismatch_count <= 10)
               $display("%0t: result with nothing expected: hit=%b src_id=%0d",
                        $realtime, rsp_bus.hit, rsp_bus.found_src_id);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.hit !== want.hit || rsp_bus.found_src_id !== want.found_src_id) begin
               mismatch_count++;
               if (unexpected_count + mismatch_count <= 10)
                  $display("%0t: mismatch: hit exp=%b act=%b, src_id exp=%0d act=%0d",
                           $realtime, want.hit, rsp_bus.hit, want.found_src_id,
                           rsp_bus.found_src_id);
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
         $display("hashed_8way_result_cache_tb NOT OK");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.cmd          = CMD_LOOKUP;
      req_bus.file_number  = '0;
      req_bus.device_id    = '0;
      req_bus.entry_src_id = '0;
      reset                = 1'b1;
      req_idle_on          = 1'b0;
      rsp_idle_on          = 1'b0;
      mismatch_count       = 0;
      unexpected_count     = 0;
      stall_cycles         = 0;
      items_sent           = 0;
      results_seen         = 0;
      hits_seen            = 0;
      foreach (cmd_count[c]) cmd_count[c] = 0;
      foreach (shadow_valid[t, v]) begin
         shadow_valid[t][v] = 1'b0;
         shadow_file[t][v]  = '0;
         shadow_dev[t][v]   = '0;
         shadow_src[t][v]   = '0;
      end
      foreach (shadow_victim[t]) shadow_victim[t] = '0;

      // Pick colliding file numbers by searching for keys that hash to each hot set.
      device_pool[0] = 32'h0;
      device_pool[1] = 32'hFFFF_FFFF;
      device_pool[2] = $urandom;
      device_pool[3] = $urandom;
      for (int h = 0; h < HOT_SETS; h++) begin
         int target;
         target = $urandom_range(0, SETS - 1);
         for (int k = 0; k < HOT_KEYS; k++) begin
            logic [31:0] cand;
            cand = $urandom;
            while (set_index(cand) != target) cand = $urandom;
            hot_file[h][k] = cand;
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_idle(330);
      test_drain_pauses(6);
      test_random_back_to_back(240);
      test_noise(140);

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Sent %0d items: %0d lookups, %0d inserts, %0d removes, %0d device sweeps,",
               items_sent, cmd_count[CMD_LOOKUP], cmd_count[CMD_INSERT],
               cmd_count[CMD_REMOVE], cmd_count[CMD_REMOVE_DEVICE]);
      $display("%0d flushes; %0d results checked, %0d of them hits.",
               cmd_count[CMD_FLUSH], results_seen, hits_seen);
      if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0) begin
         $display("hashed_8way_result_cache_tb OK");
      end else begin
         $display("%0d mismatches, %0d unexpected results, %0d missing results",
                  mismatch_count, unexpected_count, pending_results.size());
         $display("hashed_8way_result_cache_tb NOT OK");
      end
      $finish;
   end

endmodule
